// ===== rtl/text_grid_console_writer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text grid console writer
// ----------------------------------------------------------------------------
`ifndef TEXT_GRID_CONSOLE_WRITER_MACROS_SVH
`define TEXT_GRID_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication
`define TGCW_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tgcw: assertion failed");

// next-cycle implication
`define TGCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tgcw: assertion failed");

`endif

// ===== rtl/tgcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgcw_pkg
// Shared constants for the text grid console writer: field widths, item
// kinds, character codes and default grid size.
// ----------------------------------------------------------------------------
package tgcw_pkg;

  localparam int KIND_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int COORD_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 6;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BS        = 8'h08;
  localparam logic [BYTE_W-1:0] CH_PRINT_MIN = 8'd32;

  localparam int ROWS_DEFAULT = 32;
  localparam int COLS_DEFAULT = 64;

endpackage

// ===== rtl/tgcw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgcw channel interfaces
// Valid/ready channels for command items in and result items out.
// ----------------------------------------------------------------------------
interface tgcw_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [tgcw_pkg::KIND_W-1:0]           kind;
  logic [tgcw_pkg::BYTE_W-1:0]           data_byte;
  logic signed [tgcw_pkg::COORD_W-1:0]   target_row;
  logic signed [tgcw_pkg::COORD_W-1:0]   target_column;

  modport source (output valid, kind, data_byte, target_row, target_column,
                  input ready);
  modport sink   (input valid, kind, data_byte, target_row, target_column,
                  output ready);
endinterface

interface tgcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tgcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tgcw_pkg::COL_W-1:0]    cursor_column;
  logic [tgcw_pkg::BYTE_W-1:0]   cell_value;
  logic                          scrolled;

  modport source (output valid, cursor_row, cursor_column, cell_value, scrolled,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_column, cell_value, scrolled,
                  output ready);
endinterface

// ===== rtl/tgcw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tgcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/text_grid_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_grid_console_writer
// Character-cell text console with cursor, scroll by ring offset and a
// single cell store in RAM.
// ----------------------------------------------------------------------------
// Write and set-cursor items have their result registered straight away; a
// read first registers the RAM data and then the result built from it. A
// store that wraps past the last row, or a newline there, scrolls the grid:
// the result appears at once, then the new bottom row is blanked one cell
// per cycle before the next item is taken. A clear item also registers its
// result at once; then it, like reset, blanks the whole RAM one cell per
// cycle, all 2**(clog2(ROWS)+clog2(COLS)) cells (2048 for 32 x 64), before
// the next item is taken. There is one result register, so an item is only
// taken once that register is free or being drained. Cells are kept at
// address {physical row, column}, the physical row being the logical row
// plus the top-row offset modulo ROWS.
// ----------------------------------------------------------------------------
`include "text_grid_console_writer_macros.svh"

module text_grid_console_writer #(
  parameter int ROWS = tgcw_pkg::ROWS_DEFAULT,
  parameter int COLS = tgcw_pkg::COLS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  tgcw_in_if.sink      in_ch,
  tgcw_out_if.source   out_ch
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
  localparam logic [RW:0]   ROWS_W   = (RW + 1)'(ROWS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [1:0]    state_r,      state_nxt;
  logic [RW-1:0] cur_row_r,    cur_row_nxt;
  logic [CW-1:0] cur_col_r,    cur_col_nxt;
  logic [RW-1:0] top_r,        top_nxt;
  logic [AW-1:0] sweep_addr_r, sweep_addr_nxt;
  logic          sweep_full_r, sweep_full_nxt;
  logic          rd_space_r,   rd_space_nxt;

  logic                          out_valid_r,    out_valid_nxt;
  logic [tgcw_pkg::BYTE_W-1:0]   out_cell_r,     out_cell_nxt;
  logic                          out_scrolled_r, out_scrolled_nxt;
  logic [RW-1:0]                 out_row_r,      out_row_nxt;
  logic [CW-1:0]                 out_col_r,      out_col_nxt;

  logic                          in_fire;
  logic                          out_free;
  logic                          sweep_done;
  logic                          scroll;
  logic                          row_ok;
  logic                          col_ok;
  logic [tgcw_pkg::COORD_W-1:0]  trow_u;
  logic [tgcw_pkg::COORD_W:0]    tcol_u;
  logic [RW-1:0]                 trow_idx;
  logic [CW-1:0]                 tcol_idx;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [tgcw_pkg::BYTE_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [tgcw_pkg::BYTE_W-1:0]   ram_rdata;

  logic [RW:0]                   wr_sum;
  logic [RW:0]                   wr_phys;
  logic [RW:0]                   rd_sum;
  logic [RW:0]                   rd_phys;
  logic [RW+tgcw_pkg::ROW_W-1:0] row_ext;
  logic [CW+tgcw_pkg::COL_W-1:0] col_ext;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // target coordinates: sign bit rules out negatives, then compare magnitude
  assign trow_u   = $unsigned(in_ch.target_row);
  assign tcol_u   = {1'b0, $unsigned(in_ch.target_column)};
  assign row_ok   = !trow_u[tgcw_pkg::COORD_W-1] &&
                    (trow_u < tgcw_pkg::COORD_W'(ROWS));
  assign col_ok   = !tcol_u[tgcw_pkg::COORD_W-1] &&
                    (tcol_u < (tgcw_pkg::COORD_W + 1)'(COLS));
  assign trow_idx = trow_u[RW-1:0];
  assign tcol_idx = tcol_u[CW-1:0];

  // ring offset: both terms below ROWS, so one conditional subtract
  assign wr_sum  = {1'b0, top_r} + {1'b0, cur_row_r};
  assign wr_phys = (wr_sum >= ROWS_W) ? (wr_sum - ROWS_W) : wr_sum;
  assign rd_sum  = {1'b0, top_r} + {1'b0, trow_idx};
  assign rd_phys = (rd_sum >= ROWS_W) ? (rd_sum - ROWS_W) : rd_sum;

  assign sweep_done = sweep_full_r ? (sweep_addr_r == '1)
                                   : (sweep_addr_r[CW-1:0] == COL_LAST);

  always_comb begin
    state_nxt        = state_r;
    cur_row_nxt      = cur_row_r;
    cur_col_nxt      = cur_col_r;
    top_nxt          = top_r;
    sweep_addr_nxt   = sweep_addr_r;
    sweep_full_nxt   = sweep_full_r;
    rd_space_nxt     = rd_space_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_cell_nxt     = out_cell_r;
    out_scrolled_nxt = out_scrolled_r;
    out_row_nxt      = out_row_r;
    out_col_nxt      = out_col_r;
    scroll           = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = {wr_phys[RW-1:0], cur_col_r};
    ram_wdata        = in_ch.data_byte;
    ram_re           = 1'b0;
    ram_raddr        = {rd_phys[RW-1:0], tcol_idx};

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.kind)
            tgcw_pkg::KIND_WRITE: begin
              priority if (in_ch.data_byte == tgcw_pkg::CH_NEWLINE) begin
                scroll      = (cur_row_r == ROW_LAST);
                cur_col_nxt = '0;
                if (!scroll) begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else if (in_ch.data_byte == tgcw_pkg::CH_CR) begin
                cur_col_nxt = '0;
              end else if (in_ch.data_byte == tgcw_pkg::CH_BS) begin
                if (cur_col_r != '0) begin
                  cur_col_nxt = cur_col_r - 1'b1;
                end
              end else if (in_ch.data_byte >= tgcw_pkg::CH_PRINT_MIN) begin
                ram_we = 1'b1;
                if (cur_col_r == COL_LAST) begin
                  scroll      = (cur_row_r == ROW_LAST);
                  cur_col_nxt = '0;
                  if (!scroll) begin
                    cur_row_nxt = cur_row_r + 1'b1;
                  end
                end else begin
                  cur_col_nxt = cur_col_r + 1'b1;
                end
              end else begin
                // other control bytes do nothing
              end
              if (scroll) begin
                // old top row becomes the new bottom row
                top_nxt        = (top_r == ROW_LAST) ? '0 : top_r + 1'b1;
                sweep_addr_nxt = {top_r, CW'(0)};
                sweep_full_nxt = 1'b0;
                state_nxt      = ST_SWEEP;
              end
            end
            tgcw_pkg::KIND_SET: begin
              if (row_ok) begin
                cur_row_nxt = trow_idx;
              end
              if (col_ok) begin
                cur_col_nxt = tcol_idx;
              end
            end
            tgcw_pkg::KIND_CLEAR: begin
              cur_row_nxt    = '0;
              cur_col_nxt    = '0;
              top_nxt        = '0;
              sweep_addr_nxt = '0;
              sweep_full_nxt = 1'b1;
              state_nxt      = ST_SWEEP;
            end
            tgcw_pkg::KIND_READ: begin
              ram_re       = row_ok && col_ok;
              rd_space_nxt = !(row_ok && col_ok);
              state_nxt    = ST_READ;
            end
            default: begin
            end
          endcase
          if (in_ch.kind != tgcw_pkg::KIND_READ) begin
            out_valid_nxt    = 1'b1;
            out_cell_nxt     = '0;
            out_scrolled_nxt = scroll;
            out_row_nxt      = cur_row_nxt;
            out_col_nxt      = cur_col_nxt;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt    = 1'b1;
        out_cell_nxt     = rd_space_r ? tgcw_pkg::CH_SPACE : ram_rdata;
        out_scrolled_nxt = 1'b0;
        out_row_nxt      = cur_row_r;
        out_col_nxt      = cur_col_r;
        state_nxt        = ST_IDLE;
      end
      ST_SWEEP: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_addr_r;
        ram_wdata      = tgcw_pkg::CH_SPACE;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_full_r <= 1'b1;
      sweep_addr_r <= '0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      top_r        <= '0;
      rd_space_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_full_r <= sweep_full_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      top_r        <= top_nxt;
      rd_space_r   <= rd_space_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cell_r     <= out_cell_nxt;
    out_scrolled_r <= out_scrolled_nxt;
    out_row_r      <= out_row_nxt;
    out_col_r      <= out_col_nxt;
  end

  tgcw_ram #(
    .WIDTH (tgcw_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign row_ext = {{tgcw_pkg::ROW_W{1'b0}}, out_row_r};
  assign col_ext = {{tgcw_pkg::COL_W{1'b0}}, out_col_r};

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cursor_row    = row_ext[tgcw_pkg::ROW_W-1:0];
  assign out_ch.cursor_column = col_ext[tgcw_pkg::COL_W-1:0];
  assign out_ch.cell_value    = out_cell_r;
  assign out_ch.scrolled      = out_scrolled_r;

  `TGCW_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_fire)
  `TGCW_ASSERT_IMPL(a_scroll_home, clk, rst_n, out_valid_r && out_scrolled_r,
                    cur_row_r == ROW_LAST && cur_col_r == '0)
  `TGCW_ASSERT_NEXT(a_read_wait, clk, rst_n, in_fire && in_ch.kind == tgcw_pkg::KIND_READ,
                    state_r == ST_READ && !out_valid_r)

endmodule

// ===== verif/text_grid_console_writer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_grid_console_writer_tb
// Self-checking bench for the text console. Command items are pushed through
// the input channel with random gaps and results are drained with random
// stalls. A shadow console (cells, cursor, ring offset) predicts every result.
// Each result is compared field by field in arrival order. Directed tests
// cover byte extremes, control bytes, cursor limits, wrap and scroll,
// out-of-range reads and clear. Random traffic follows, mostly text lines,
// cursor moves and readback.
// ----------------------------------------------------------------------------
module text_grid_console_writer_tb;

  localparam int ROWS          = tgcw_pkg::ROWS_DEFAULT;
  localparam int COLS          = tgcw_pkg::COLS_DEFAULT;
  localparam int CELL_COUNT    = ROWS * COLS;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int PRESSURE_HOLD = 400;
  // room for a full clear sweep, plus the longest result stall
  localparam int STALL_LIMIT   = 12000;
  localparam int DRAIN_CYCLES  = 2 * COLS + 32;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [tgcw_pkg::ROW_W-1:0]  row;
    logic [tgcw_pkg::COL_W-1:0]  col;
    logic [tgcw_pkg::BYTE_W-1:0] cell_val;
    logic                        scrolled;
  } console_result_t;

  logic clk;
  logic rst_n;

  tgcw_in_if  in_ch ();
  tgcw_out_if out_ch ();

  text_grid_console_writer #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow console
  logic [tgcw_pkg::BYTE_W-1:0] shadow_cells [CELL_COUNT];
  int unsigned       shadow_row;
  int unsigned       shadow_col;
  int unsigned       shadow_top;

  console_result_t   pending_results [$];

  int unsigned sent_items;
  int unsigned fail_count;
  int unsigned write_count;
  int unsigned set_count;
  int unsigned clear_count;
  int unsigned read_count;
  int unsigned scroll_count;
  int unsigned idle_cycles;

  bit quiet_mode;
  bit stall_free;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void blank_shadow();
    int i;
    for (i = 0; i < CELL_COUNT; i++) shadow_cells[i] = tgcw_pkg::CH_SPACE;
  endfunction

  function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
    return ((shadow_top + r) % ROWS) * COLS + (c % COLS);
  endfunction

  // returns 1 when the grid scrolled up
  function automatic bit advance_line();
    int unsigned bottom;
    int c;
    shadow_col = 0;
    if (shadow_row + 1 < ROWS) begin
      shadow_row++;
      return 1'b0;
    end
    shadow_top = (shadow_top + 1) % ROWS;
    bottom     = (shadow_top + ROWS - 1) % ROWS;
    for (c = 0; c < COLS; c++) shadow_cells[bottom * COLS + c] = tgcw_pkg::CH_SPACE;
    shadow_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic console_result_t predict_console(
    input logic [tgcw_pkg::KIND_W-1:0]         kind,
    input logic [tgcw_pkg::BYTE_W-1:0]         data_b,
    input logic signed [tgcw_pkg::COORD_W-1:0] trow,
    input logic signed [tgcw_pkg::COORD_W-1:0] tcol
  );
    console_result_t res;
    int r;
    int c;
    res = '0;
    r   = trow;
    c   = tcol;
    case (kind)
      tgcw_pkg::KIND_WRITE: begin
        if (data_b == tgcw_pkg::CH_NEWLINE) begin
          res.scrolled = advance_line();
        end else if (data_b == tgcw_pkg::CH_CR) begin
          shadow_col = 0;
        end else if (data_b == tgcw_pkg::CH_BS) begin
          if (shadow_col > 0) shadow_col--;
        end else if (data_b >= tgcw_pkg::CH_PRINT_MIN) begin
          shadow_cells[cell_addr(shadow_row, shadow_col)] = data_b;
          shadow_col++;
          if (shadow_col >= COLS) res.scrolled = advance_line();
        end
      end
      tgcw_pkg::KIND_SET: begin
        if (r >= 0 && r < ROWS) shadow_row = r;
        if (c >= 0 && c < COLS) shadow_col = c;
      end
      tgcw_pkg::KIND_CLEAR: begin
        blank_shadow();
        shadow_top = 0;
        shadow_row = 0;
        shadow_col = 0;
      end
      default: begin
        if (r >= 0 && r < ROWS && c >= 0 && c < COLS)
          res.cell_val = shadow_cells[cell_addr(r, c)];
        else
          res.cell_val = tgcw_pkg::CH_SPACE;
      end
    endcase
    res.row = tgcw_pkg::ROW_W'(shadow_row);
    res.col = tgcw_pkg::COL_W'(shadow_col);
    return res;
  endfunction

  // ----------------------------------------------------------------- checking
  task automatic note_failure(input string msg);
    if (fail_count < MAX_REPORTS) $display("%t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : result_monitor
    console_result_t want;
    console_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = predict_console(in_ch.kind, in_ch.data_byte, in_ch.target_row,
                               in_ch.target_column);
        pending_results.push_back(want);
        case (in_ch.kind)
          tgcw_pkg::KIND_WRITE: write_count++;
          tgcw_pkg::KIND_SET:   set_count++;
          tgcw_pkg::KIND_CLEAR: clear_count++;
          default:              read_count++;
        endcase
        if (want.scrolled) scroll_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.cursor_row, out_ch.cursor_column, out_ch.cell_value,
                out_ch.scrolled};
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result with none pending: row %0d col %0d cell %02h scr %0b",
                                 got.row, got.col, got.cell_val, got.scrolled));
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            note_failure($sformatf(
              "mismatch: exp row %0d col %0d cell %02h scr %0b, got row %0d col %0d cell %02h scr %0b",
              want.row, want.col, want.cell_val, want.scrolled,
              got.row, got.col, got.cell_val, got.scrolled));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               idle_cycles, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------------ idling
  // mostly back to back or short, now and then a long gap
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (quiet_mode) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_ready_driver
    int unsigned run_len;
    bit level;
    out_ch.ready <= 1'b0;
    run_len = 0;
    level   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
        run_len = 0;
        level   = 1'b0;
      end
      if (run_len == 0) begin
        if (stall_free) begin
          level   = 1'b1;
          run_len = 8;
        end else if (level) begin
          level   = 1'b0;
          run_len = pick_gap() + 1;
        end else begin
          level   = 1'b1;
          run_len = $urandom_range(1, 24);
        end
      end
      out_ch.ready <= level;
      run_len--;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_item(
    input logic [tgcw_pkg::KIND_W-1:0]         kind,
    input logic [tgcw_pkg::BYTE_W-1:0]         data_b,
    input logic signed [tgcw_pkg::COORD_W-1:0] trow,
    input logic signed [tgcw_pkg::COORD_W-1:0] tcol
  );
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.data_byte     <= data_b;
    in_ch.target_row    <= trow;
    in_ch.target_column <= tcol;
    do @(posedge clk); while (!in_ch.ready);
    // ignored control bytes do not count
    if (!(kind == tgcw_pkg::KIND_WRITE && data_b < tgcw_pkg::CH_PRINT_MIN &&
          data_b != tgcw_pkg::CH_NEWLINE && data_b != tgcw_pkg::CH_CR &&
          data_b != tgcw_pkg::CH_BS))
      sent_items++;
  endtask

  task automatic write_byte(input logic [tgcw_pkg::BYTE_W-1:0] b);
    send_item(tgcw_pkg::KIND_WRITE, b, tgcw_pkg::COORD_W'($urandom),
              tgcw_pkg::COORD_W'($urandom));
  endtask

  task automatic set_cursor(input int r, input int c);
    send_item(tgcw_pkg::KIND_SET, tgcw_pkg::BYTE_W'($urandom), tgcw_pkg::COORD_W'(r),
              tgcw_pkg::COORD_W'(c));
  endtask

  task automatic read_cell(input int r, input int c);
    send_item(tgcw_pkg::KIND_READ, tgcw_pkg::BYTE_W'($urandom), tgcw_pkg::COORD_W'(r),
              tgcw_pkg::COORD_W'(c));
  endtask

  task automatic clear_grid();
    send_item(tgcw_pkg::KIND_CLEAR, tgcw_pkg::BYTE_W'($urandom),
              tgcw_pkg::COORD_W'($urandom), tgcw_pkg::COORD_W'($urandom));
  endtask

  function automatic logic [tgcw_pkg::BYTE_W-1:0] pick_text_byte();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 85) return tgcw_pkg::BYTE_W'($urandom_range(32, 255));
    if (p < 90) return tgcw_pkg::CH_NEWLINE;
    if (p < 94) return tgcw_pkg::CH_CR;
    if (p < 97) return tgcw_pkg::CH_BS;
    return tgcw_pkg::BYTE_W'($urandom_range(0, 31));
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_reset_state();
    read_cell(0, 0);
    read_cell(ROWS - 1, COLS - 1);
  endtask

  task automatic test_printable_bytes();
    write_byte(tgcw_pkg::CH_SPACE);
    write_byte(8'h41);
    write_byte(8'h7F);
    write_byte(8'hFF);
    read_cell(0, 3);
  endtask

  task automatic test_control_bytes();
    write_byte(tgcw_pkg::CH_BS);
    write_byte(tgcw_pkg::CH_CR);
    write_byte(tgcw_pkg::CH_BS);     // already at column 0
    write_byte(8'h00);
    write_byte(8'h1F);
    write_byte(tgcw_pkg::CH_NEWLINE);
  endtask

  task automatic test_cursor_set();
    set_cursor(ROWS - 1, COLS - 1);
    set_cursor(-128, 127);
    set_cursor(0, -1);     // row moves, column kept
    set_cursor(ROWS, COLS);
  endtask

  task automatic test_scroll();
    set_cursor(ROWS - 1, COLS - 2);
    write_byte(8'h78);
    write_byte(8'h79);     // last column: wraps and scrolls
    write_byte(tgcw_pkg::CH_NEWLINE); // newline on last row scrolls again
  endtask

  task automatic test_read_range();
    read_cell(-1, 0);
    read_cell(0, COLS);
    read_cell(ROWS - 3, COLS - 1);
    read_cell(127, -128);
  endtask

  task automatic test_clear();
    clear_grid();
    read_cell(ROWS - 3, COLS - 1);
  endtask

  // result side holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    int i;
    quiet_mode   = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 40; i++) begin
      if (i % 5 == 4) read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
      else write_byte(pick_text_byte());
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned p;
    int n;
    int i;
    goal = sent_items + RANDOM_ITEMS;
    while (sent_items < goal) begin
      quiet_mode = ($urandom_range(0, 9) == 0);
      stall_free = quiet_mode;
      p = $urandom_range(0, 99);
      if (p < 38) begin
        n = $urandom_range(1, 80);
        for (i = 0; i < n; i++) write_byte(pick_text_byte());
      end else if (p < 46) begin
        if ($urandom_range(0, 1))
          set_cursor(ROWS - 1 - $urandom_range(0, 2), $urandom_range(0, COLS - 1));
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) write_byte(tgcw_pkg::CH_NEWLINE);
      end else if (p < 62) begin
        if ($urandom_range(0, 4) == 0)
          set_cursor($urandom_range(0, 255), $urandom_range(0, 255));
        else
          set_cursor($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
      end else if (p < 88) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 6) == 0)
            read_cell($urandom_range(0, 255), $urandom_range(0, 255));
          else
            read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
        end
      end else if (p < 90) begin
        clear_grid();
      end else begin
        // noise: any kind but clear, every field random
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
          send_item(tgcw_pkg::KIND_W'($urandom_range(0, 2)) == tgcw_pkg::KIND_CLEAR
                      ? tgcw_pkg::KIND_READ : tgcw_pkg::KIND_W'($urandom_range(0, 1)),
                    tgcw_pkg::BYTE_W'($urandom), tgcw_pkg::COORD_W'($urandom),
                    tgcw_pkg::COORD_W'($urandom));
      end
    end
    quiet_mode = 1'b0;
    stall_free = 1'b0;
  endtask

  // -------------------------------------------------------------------- main
  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= tgcw_pkg::KIND_WRITE;
    in_ch.data_byte     <= '0;
    in_ch.target_row    <= '0;
    in_ch.target_column <= '0;
    quiet_mode   = 1'b0;
    stall_free   = 1'b0;
    hold_request = 1'b0;
    sent_items   = 0;
    fail_count   = 0;
    write_count  = 0;
    set_count    = 0;
    clear_count  = 0;
    read_count   = 0;
    scroll_count = 0;
    idle_cycles  = 0;
    blank_shadow();
    shadow_row = 0;
    shadow_col = 0;
    shadow_top = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_printable_bytes();
    test_control_bytes();
    test_cursor_set();
    test_scroll();
    test_read_range();
    test_clear();
    test_backpressure();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a trailing scroll may still be blanking its row
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("covered %0d items: %0d writes, %0d cursor sets, %0d clears, %0d reads",
             write_count + set_count + clear_count + read_count, write_count, set_count,
             clear_count, read_count);
    $display("grid scrolled %0d times, %0d failures", scroll_count, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== text_grid_console_writer.f =====
+incdir+rtl
rtl/tgcw_pkg.sv
rtl/tgcw_if.sv
rtl/tgcw_ram.sv
rtl/text_grid_console_writer.sv
verif/text_grid_console_writer_tb.sv
